// ----- design/text_console_cell_writer_unit_macros.svh -----
// Assertion macros for the console cell writer RTL.
// Each macro expects aclk and aresetn to be in scope at the point of use.
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define TCCW_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication.
`define TCCW_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tccw_pkg.sv -----
// Shared types and constants for the text console cell writer.
// No dependencies; used by the front end, command queue, back end and top level.
`default_nettype none

package tccw_pkg;

    // Field widths fixed by the channel formats
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;

    // Request codes
    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] char_code;
        logic [CHAR_W-1:0] color;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } in_item_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              scrolled;
    } out_item_t;

    // Command kinds handed from front to back
    typedef enum logic [1:0] {
        CMD_READ,
        CMD_PUT,
        CMD_CR,
        CMD_LF
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              tab;       // repeat the space TAB_WIDTH times
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] color;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
        logic              in_range;  // read position lies on the screen
    } cmd_t;

endpackage

`default_nettype wire

// ----- design/tccw_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/tccw_front.sv -----
// Front end: accepts input transfers and classifies them into commands.
// Depends on tccw_pkg.
`default_nettype none

module tccw_front #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic              s_valid,
    output      logic              s_ready,
    input  wire tccw_pkg::in_item_t s_data,
    input  wire logic              init_done,
    output      logic              push_valid,
    input  wire logic              push_ready,
    output      tccw_pkg::cmd_t    push_data
);

    // Hold off transfers until the screen clear has finished
    assign s_ready    = init_done && push_ready;
    assign push_valid = s_valid && init_done;

    // Classify the request
    always_comb begin
        push_data.tab      = 1'b0;
        push_data.ch       = s_data.char_code;
        push_data.color    = s_data.color;
        push_data.read_row = s_data.read_row;
        push_data.read_col = s_data.read_col;
        push_data.in_range = (32'(s_data.read_row) < 32'(ROWS))
                          && (32'(s_data.read_col) < 32'(COLS));
        if (s_data.req_type == tccw_pkg::REQ_READ) begin
            push_data.kind = tccw_pkg::CMD_READ;
        end else if (s_data.char_code == tccw_pkg::CH_CR) begin
            push_data.kind = tccw_pkg::CMD_CR;
        end else if (s_data.char_code == tccw_pkg::CH_LF) begin
            push_data.kind = tccw_pkg::CMD_LF;
        end else if (s_data.char_code == tccw_pkg::CH_TAB) begin
            push_data.kind = tccw_pkg::CMD_PUT;
            push_data.tab  = 1'b1;
            push_data.ch   = tccw_pkg::CH_SPACE;
        end else begin
            push_data.kind = tccw_pkg::CMD_PUT;
        end
    end

endmodule

`default_nettype wire

// ----- design/tccw_cmd_queue.sv -----
// Short command FIFO between the front end and the back end.
// Depends on tccw_pkg.
`default_nettype none

module tccw_cmd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output      logic           push_ready,
    input  wire tccw_pkg::cmd_t push_data,
    output      logic           pop_valid,
    input  wire logic           pop_ready,
    output      tccw_pkg::cmd_t pop_data
);

    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    tccw_pkg::cmd_t  slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]  count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CNW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/tccw_back.sv -----
// Back end: screen memory, cursor, scroll sequencer and result register.
// Depends on tccw_pkg, tccw_ram and the assertion macro header.
`default_nettype none
`include "text_console_cell_writer_unit_macros.svh"

module tccw_back #(
    parameter int ROWS      = 25,
    parameter int COLS      = 80,
    parameter int TAB_WIDTH = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               pop_valid,
    output      logic               pop_ready,
    input  wire tccw_pkg::cmd_t     pop_data,
    output      logic               init_done,
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      tccw_pkg::out_item_t m_data
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int NCELL = ROWS * COLS;
    localparam int AW    = $clog2(NCELL);
    localparam int TW    = $clog2(TAB_WIDTH + 1);

    localparam logic [AW-1:0] CLEAR_LAST  = AW'(NCELL - 1);
    localparam logic [AW-1:0] SCROLL_LAST = AW'((ROWS - 1) * COLS - 1);
    localparam logic [AW-1:0] KEEP_CELLS  = AW'((ROWS - 2) * COLS);
    localparam logic [AW-1:0] BOTTOM_BASE = AW'((ROWS - 1) * COLS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_PUT,
        S_SCROLL,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [CW-1:0]          col_reg, col_next;
    logic [AW-1:0]          clr_idx_reg, clr_idx_next;
    logic [AW-1:0]          scr_idx_reg, scr_idx_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [AW-1:0]          pend_dst_reg, pend_dst_next;
    logic [TW-1:0]          remain_reg, remain_next;
    tccw_pkg::cmd_t         cmd_reg, cmd_next;
    logic [tccw_pkg::CELL_W-1:0] cell_reg, cell_next;
    logic                   scrolled_reg, scrolled_next;
    logic                   m_valid_reg, m_valid_next;
    tccw_pkg::out_item_t    m_data_reg, m_data_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [tccw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    logic [RW+tccw_pkg::ROW_W-1:0] head_row_ext;
    logic [RW-1:0]          head_row;
    logic [AW-1:0]          head_addr, cur_addr;
    logic [CW:0]            col_inc;
    logic [RW:0]            row_inc;
    logic [CW:0]            put_col;
    logic [RW:0]            put_row;
    logic [RW+tccw_pkg::ROW_W-1:0] row_out_ext;
    logic [CW+tccw_pkg::COL_W-1:0] col_out_ext;

    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (NCELL)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Cell addresses for the queue head read and the cursor
    assign head_row_ext = {RW'(0), pop_data.read_row};
    assign head_row     = head_row_ext[RW-1:0];
    assign head_addr    = AW'(head_row) * AW'(COLS) + AW'(pop_data.read_col[CW-1:0]);
    assign cur_addr     = AW'(row_reg) * AW'(COLS) + AW'(col_reg);

    // Cursor advance for one put or line feed
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign row_inc = {1'b0, row_reg} + 1'b1;

    always_comb begin
        put_col = col_inc;
        put_row = {1'b0, row_reg};
        if (cmd_reg.kind == tccw_pkg::CMD_LF) begin
            put_col = '0;
            put_row = row_inc;
        end else if (col_inc >= (CW+1)'(COLS)) begin
            put_col = '0;
            put_row = row_inc;
        end
    end

    // Cursor fields fitted to the result widths
    assign row_out_ext = {tccw_pkg::ROW_W'(0), row_reg};
    assign col_out_ext = {tccw_pkg::COL_W'(0), col_reg};

    assign pop_ready = (state_reg == S_IDLE);
    assign init_done = (state_reg != S_CLEAR);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Sequencer next state and memory port control
    always_comb begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        clr_idx_next    = clr_idx_reg;
        scr_idx_next    = scr_idx_reg;
        pend_valid_next = 1'b0;
        pend_dst_next   = pend_dst_reg;
        remain_next     = remain_reg;
        cmd_next        = cmd_reg;
        cell_next       = cell_reg;
        scrolled_next   = scrolled_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        // Pending scroll write lands in the cycle after its read
        ram_we    = pend_valid_reg;
        ram_waddr = pend_dst_reg;
        ram_wdata = (pend_dst_reg < KEEP_CELLS) ? ram_rdata : '0;
        ram_re    = 1'b0;
        ram_raddr = scr_idx_reg + AW'(COLS);

        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
                if (clr_idx_reg == CLEAR_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (pop_valid) begin
                    cmd_next      = pop_data;
                    cell_next     = '0;
                    scrolled_next = 1'b0;
                    remain_next   = pop_data.tab ? TW'(TAB_WIDTH) : TW'(1);
                    if (pop_data.kind == tccw_pkg::CMD_READ) begin
                        ram_re     = pop_data.in_range;
                        ram_raddr  = head_addr;
                        state_next = S_READ;
                    end else begin
                        state_next = S_PUT;
                    end
                end
            end
            S_READ: begin
                cell_next  = cmd_reg.in_range ? ram_rdata : '0;
                state_next = S_DONE;
            end
            S_PUT: begin
                if (cmd_reg.kind == tccw_pkg::CMD_CR) begin
                    col_next   = '0;
                    state_next = S_DONE;
                end else begin
                    if (cmd_reg.kind == tccw_pkg::CMD_PUT) begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_addr;
                        ram_wdata = {cmd_reg.color, cmd_reg.ch};
                    end
                    remain_next = remain_reg - 1'b1;
                    col_next    = put_col[CW-1:0];
                    if (put_row >= (RW+1)'(ROWS - 1)) begin
                        row_next      = RW'(ROWS - 2);
                        scrolled_next = 1'b1;
                        scr_idx_next  = '0;
                        state_next    = S_SCROLL;
                    end else begin
                        row_next   = put_row[RW-1:0];
                        state_next = (remain_reg == TW'(1)) ? S_DONE : S_PUT;
                    end
                end
            end
            S_SCROLL: begin
                // Read row r+1 while the previous cell is written to row r
                ram_re          = 1'b1;
                pend_valid_next = 1'b1;
                pend_dst_next   = scr_idx_reg;
                if (scr_idx_reg == SCROLL_LAST) begin
                    state_next = S_DRAIN;
                end else begin
                    scr_idx_next = scr_idx_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                state_next = (remain_reg == '0) ? S_DONE : S_PUT;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.cell_value = cell_reg;
                    m_data_next.cursor_row = row_out_ext[tccw_pkg::ROW_W-1:0];
                    m_data_next.cursor_col = col_out_ext[tccw_pkg::COL_W-1:0];
                    m_data_next.scrolled   = scrolled_reg;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, cursor and result register
    always_ff @(posedge aclk) begin
        scr_idx_reg  <= scr_idx_next;
        pend_dst_reg <= pend_dst_next;
        remain_reg   <= remain_next;
        cmd_reg      <= cmd_next;
        cell_reg     <= cell_next;
        scrolled_reg <= scrolled_next;
        m_data_reg   <= m_data_next;
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            row_reg        <= '0;
            col_reg        <= '0;
            clr_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            clr_idx_reg    <= clr_idx_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Checks
    `TCCW_ASSERT(a_bottom_row_untouched, !(ram_we && (ram_waddr >= BOTTOM_BASE) && (state_reg != S_CLEAR)), "write into bottom row outside clear")
    `TCCW_ASSERT_IMPL(a_pend_in_scroll, pend_valid_reg, (state_reg == S_SCROLL) || (state_reg == S_DRAIN), "scroll write outside scroll")
    `TCCW_ASSERT_IMPL(a_scroll_cursor, state_reg == S_SCROLL, (row_reg == RW'(ROWS - 2)) && scrolled_reg, "cursor not parked during scroll")
    `TCCW_ASSERT_NEXT(a_result_waits, (state_reg == S_DONE) && m_valid_reg && !m_ready, state_reg == S_DONE, "result loaded over a pending transfer")

endmodule

`default_nettype wire

// ----- design/text_console_cell_writer_unit.sv -----
// Top level of the text console cell writer: front end, command queue, back end.
// Depends on tccw_pkg, tccw_front, tccw_cmd_queue and tccw_back.
//
// Text console engine over a ROWS x COLS screen of 16-bit cells ({color, char}) with a
// cursor. After reset the screen memory is cleared in one pass during which no input
// transfer is taken. Commands are classified on input and queued, so new items are taken
// while the back end works and a result waits in the output register, as long as the
// queue has room. A read or a plain put passes the back end through dequeue, memory access
// and result load; a tab repeats the put step once per space. Each scroll copies the screen
// up one row, one cell per cycle through the single screen memory write port, while the
// freed row is cleared. The bottom row is written only by the clear and reads as zero.
`default_nettype none

module text_console_cell_writer_unit #(
    parameter int ROWS        = 25,
    parameter int COLS        = 80,
    parameter int TAB_WIDTH   = 8,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire tccw_pkg::in_item_t  s_data,
    output      logic                m_valid,
    input  wire logic                m_ready,
    output      tccw_pkg::out_item_t m_data
);

    logic           init_done;
    logic           push_valid, push_ready;
    tccw_pkg::cmd_t push_data;
    logic           pop_valid, pop_ready;
    tccw_pkg::cmd_t pop_data;

    tccw_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .init_done  (init_done),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tccw_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tccw_back #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .init_done (init_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
